// ----- rtl/deq_pkg.sv -----
// Shared types, widths, codes and slot arithmetic for the double-ended queue.
// Used by every module of the block but deq_ram; depends on nothing.
package deq_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 4;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int SUM_W    = COUNT_W + 1;

    typedef logic [DATA_W-1:0]  data_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ_FRONT = 3'd4,
        OP_READ_BACK  = 3'd5,
        OP_READ_INDEX = 3'd6,
        OP_CLEAR      = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic capture;
    } deq_cmd_t;

    function automatic slot_t slot_add(slot_t head, count_t offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(offset);
        if (sum >= SUM_W'(CAPACITY))
            sum = sum - SUM_W'(CAPACITY);
        return slot_t'(sum);
    endfunction

    function automatic slot_t slot_dec(slot_t head);
        slot_t res;
        if (head == '0)
            res = slot_t'(CAPACITY - 1);
        else
            res = head - 1'b1;
        return res;
    endfunction

endpackage

// ----- rtl/deq_ram.sv -----
// Generic single-port RAM with a registered read.
// Standalone; depends on nothing.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/deq_ctrl.sv -----
// Controller state machine that sequences one transaction at a time.
// Depends on deq_pkg for the command struct.
module deq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output deq_pkg::deq_cmd_t cmd
);

    import deq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CAPT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_EXEC;
            S_EXEC: state_next = S_CAPT;
            S_CAPT: state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= (state_next == S_DONE);
        end
    end

    assign cmd.load    = accept;
    assign cmd.exec    = (state_reg == S_EXEC);
    assign cmd.capture = (state_reg == S_CAPT);
    assign busy        = busy_reg;
    assign done        = done_reg;

endmodule

// ----- rtl/deq_dpath.sv -----
// Datapath: operand registers, head and count registers, entry store and result registers.
// Depends on deq_pkg and instantiates deq_ram.
module deq_dpath (
    input  logic              clk,
    input  logic              rst_n,
    input  deq_pkg::deq_cmd_t cmd,
    input  logic [2:0]        opcode,
    input  deq_pkg::data_t    item_data,
    input  deq_pkg::pos_t     position,
    output deq_pkg::data_t    read_data,
    output logic [1:0]        status,
    output deq_pkg::count_t   entry_count,
    output logic              is_empty
);

    import deq_pkg::*;

    opcode_t op_reg;
    data_t   data_reg;
    pos_t    pos_reg;
    slot_t   head_reg;
    slot_t   head_next;
    count_t  count_reg;
    count_t  count_next;
    status_t status_reg;
    status_t status_next;
    logic    rd_ok_reg;
    logic    rd_ok_next;
    data_t   read_data_reg;

    logic    ram_we;
    slot_t   ram_addr;
    data_t   ram_rdata;
    logic    full;
    logic    empty;

    assign full  = (count_reg == count_t'(CAPACITY));
    assign empty = (count_reg == '0);

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        rd_ok_next  = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = head_reg;
        unique case (op_reg)
            OP_PUSH_FRONT:
            begin
                ram_addr = slot_dec(head_reg);
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    ram_we     = cmd.exec;
                    head_next  = slot_dec(head_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            OP_PUSH_BACK:
            begin
                ram_addr = slot_add(head_reg, count_reg);
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    ram_we     = cmd.exec;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    head_next  = slot_add(head_reg, count_t'(1));
                    count_next = count_reg - 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                    count_next = count_reg - 1'b1;
            end
            OP_READ_FRONT:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                    rd_ok_next = 1'b1;
            end
            OP_READ_BACK:
            begin
                ram_addr = slot_add(head_reg, count_reg - 1'b1);
                if (empty)
                    status_next = ST_EMPTY;
                else
                    rd_ok_next = 1'b1;
            end
            OP_READ_INDEX:
            begin
                ram_addr = slot_add(head_reg, count_t'(pos_reg));
                if (count_t'(pos_reg) >= count_reg)
                    status_next = ST_RANGE;
                else
                    rd_ok_next = 1'b1;
            end
            OP_CLEAR:
            begin
                head_next  = '0;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode_t'(opcode);
            data_reg <= item_data;
            pos_reg  <= position;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            rd_ok_reg  <= rd_ok_next;
        end
        if (cmd.capture)
        begin
            read_data_reg <= rd_ok_reg ? ram_rdata : '0;
        end
    end

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (data_reg),
        .rdata (ram_rdata)
    );

    assign read_data   = read_data_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;
    assign is_empty    = (count_reg == '0);

endmodule

// ----- rtl/double_ended_queue_core.sv -----
// Top level of the bounded double-ended queue with indexed read.
// Depends on deq_pkg and instantiates deq_ctrl and deq_dpath.
//
// A transaction is accepted at a rising edge where start is high and busy is low.
// It carries opcode, item_data and position; busy rises at that edge.
// The entry store is a single-port RAM with a registered read, so each
// transaction passes through an execute state that updates the head and count
// and addresses the store, a capture state in which the store output is loaded
// into the result registers, and a done state in which the result is presented.
// done rises on entry to the done state and stays high for exactly one cycle,
// and the result is taken at the edge that ends it; busy falls at that same edge.
// A new transaction can therefore be accepted only after busy has fallen.
// Every transaction yields exactly one result; the receiver cannot stall it,
// so the result must be taken in the cycle where done is high.
// Reset empties the queue and sets the head to slot zero; store contents are
// not cleared, and no entry is reachable until a push writes it.
module double_ended_queue_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           opcode,
    input  deq_pkg::data_t       item_data,
    input  deq_pkg::pos_t        position,
    output logic                 done,
    output deq_pkg::data_t       read_data,
    output logic [1:0]           status,
    output deq_pkg::count_t      entry_count,
    output logic                 is_empty
);

    import deq_pkg::*;

    deq_cmd_t cmd;

    deq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    deq_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .opcode      (opcode),
        .item_data   (item_data),
        .position    (position),
        .read_data   (read_data),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Testbench for double_ended_queue_core: a directed table and random queue traffic.
// Each result is checked against its table row or a deque model in the bench.
// Depends on deq_pkg and the RTL of the block.
module tb;
    import deq_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 750;
    localparam int QUIET_FIRST  = 300;
    localparam int QUIET_LAST   = 450;
    localparam int PAUSE_AT     = 520;
    localparam int BIAS_SPAN    = 40;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_SHOWN    = 10;
    localparam int NUM_ROWS     = 18;

    typedef struct packed {
        data_t   rd;
        status_t st;
        count_t  cnt;
        logic    empty;
    } deq_result_t;

    typedef struct packed {
        opcode_t     op;
        data_t       data;
        pos_t        pos;
        logic [4:0]  reps;
        logic        exact;
        deq_result_t res;
    } deq_row_t;

    localparam deq_result_t NO_RESULT = '0;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    logic   [2:0] opcode;
    data_t  item_data;
    pos_t   position;
    logic   done;
    data_t  read_data;
    logic   [1:0] status;
    count_t entry_count;
    logic   is_empty;

    data_t       deque_words [CAPACITY];
    int          front_slot;
    int          fill;
    deq_result_t pending_results [$];
    deq_row_t    dir_rows [NUM_ROWS];
    int          fail_count;
    int          stall_cycles;
    bit          idle_on;

    double_ended_queue_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .item_data   (item_data),
        .position    (position),
        .done        (done),
        .read_data   (read_data),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    function automatic deq_result_t deque_apply(opcode_t op, data_t data, pos_t pos);
        deq_result_t r;
        r = NO_RESULT;
        r.st = ST_OK;
        case (op)
            OP_PUSH_FRONT:
                if (fill == CAPACITY)
                    r.st = ST_FULL;
                else
                begin
                    front_slot = (front_slot + CAPACITY - 1) % CAPACITY;
                    deque_words[front_slot] = data;
                    fill++;
                end
            OP_PUSH_BACK:
                if (fill == CAPACITY)
                    r.st = ST_FULL;
                else
                begin
                    deque_words[(front_slot + fill) % CAPACITY] = data;
                    fill++;
                end
            OP_POP_FRONT:
                if (fill == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    front_slot = (front_slot + 1) % CAPACITY;
                    fill--;
                end
            OP_POP_BACK:
                if (fill == 0)
                    r.st = ST_EMPTY;
                else
                    fill--;
            OP_READ_FRONT:
                if (fill == 0)
                    r.st = ST_EMPTY;
                else
                    r.rd = deque_words[front_slot];
            OP_READ_BACK:
                if (fill == 0)
                    r.st = ST_EMPTY;
                else
                    r.rd = deque_words[(front_slot + fill - 1) % CAPACITY];
            OP_READ_INDEX:
                if (int'(pos) >= fill)
                    r.st = ST_RANGE;
                else
                    r.rd = deque_words[(front_slot + int'(pos)) % CAPACITY];
            default:
            begin
                front_slot = 0;
                fill = 0;
            end
        endcase
        r.cnt = count_t'(fill);
        r.empty = (fill == 0);
        return r;
    endfunction

    task automatic issue(input opcode_t op, input data_t data, input pos_t pos,
                         input logic exact, input deq_result_t given);
        deq_result_t predicted;
        while (idle_on && $urandom_range(99) < 32)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start     <= 1'b1;
        opcode    <= op;
        item_data <= data;
        position  <= pos;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = deque_apply(op, data, pos);
        pending_results.push_back(exact ? given : predicted);
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        deq_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("Unexpected result: data %h status %0d count %0d empty %0b",
                             read_data, status, entry_count, is_empty);
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_data !== want.rd || status !== want.st ||
                    entry_count !== want.cnt || is_empty !== want.empty)
                begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display({"Mismatch: expected data %h status %0d count %0d empty %0b,",
                                  " got data %h status %0d count %0d empty %0b"},
                                 want.rd, want.st, want.cnt, want.empty,
                                 read_data, status, entry_count, is_empty);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int      mode;
        int      roll;
        opcode_t op;
        data_t   data;
        pos_t    pos;

        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = OP_CLEAR;
        item_data    = '0;
        position     = '0;
        fail_count   = 0;
        stall_cycles = 0;
        idle_on      = 1'b1;
        front_slot   = 0;
        fill         = 0;
        foreach (deque_words[i])
            deque_words[i] = '0;

        dir_rows = '{
            '{OP_POP_FRONT,  32'h0,        4'd0,  5'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0, 1'b1}},
            '{OP_POP_BACK,   32'h0,        4'd0,  5'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0, 1'b1}},
            '{OP_READ_FRONT, 32'h0,        4'd0,  5'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0, 1'b1}},
            '{OP_READ_BACK,  32'h0,        4'd0,  5'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0, 1'b1}},
            '{OP_READ_INDEX, 32'h0,        4'd15, 5'd1, 1'b1, '{32'h0, ST_RANGE, 5'd0, 1'b1}},
            '{OP_PUSH_BACK,  32'hFFFFFFFF, 4'd0,  5'd1, 1'b1, '{32'h0, ST_OK,    5'd1, 1'b0}},
            '{OP_PUSH_FRONT, 32'h0,        4'd0,  5'd1, 1'b1, '{32'h0, ST_OK,    5'd2, 1'b0}},
            '{OP_READ_BACK,  32'h0,        4'd0,  5'd1, 1'b1,
              '{32'hFFFFFFFF, ST_OK, 5'd2, 1'b0}},
            '{OP_READ_INDEX, 32'h0,        4'd1,  5'd1, 1'b1,
              '{32'hFFFFFFFF, ST_OK, 5'd2, 1'b0}},
            '{OP_READ_INDEX, 32'h0,        4'd2,  5'd1, 1'b1, '{32'h0, ST_RANGE, 5'd2, 1'b0}},
            '{OP_PUSH_BACK,  32'h0,        4'd0,  5'd7, 1'b0, NO_RESULT},
            '{OP_PUSH_FRONT, 32'h0,        4'd0,  5'd7, 1'b0, NO_RESULT},
            '{OP_PUSH_FRONT, 32'hA5A5A5A5, 4'd0,  5'd1, 1'b1, '{32'h0, ST_FULL,  5'd16, 1'b0}},
            '{OP_PUSH_BACK,  32'h5A5A5A5A, 4'd0,  5'd1, 1'b1, '{32'h0, ST_FULL,  5'd16, 1'b0}},
            '{OP_READ_INDEX, 32'h0,        4'd15, 5'd1, 1'b0, NO_RESULT},
            '{OP_POP_BACK,   32'h0,        4'd0,  5'd1, 1'b1, '{32'h0, ST_OK,    5'd15, 1'b0}},
            '{OP_POP_FRONT,  32'h0,        4'd0,  5'd1, 1'b1, '{32'h0, ST_OK,    5'd14, 1'b0}},
            '{OP_CLEAR,      32'h0,        4'd0,  5'd1, 1'b1, '{32'h0, ST_OK,    5'd0, 1'b1}}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Rows that repeat push fresh random words each time.
        foreach (dir_rows[i])
            for (int k = 0; k < dir_rows[i].reps; k++)
                issue(dir_rows[i].op,
                      dir_rows[i].reps > 1 ? data_t'($urandom) : dir_rows[i].data,
                      dir_rows[i].pos, dir_rows[i].exact, dir_rows[i].res);

        hold_until_drained();

        // Traffic comes in spans that lean toward filling, draining or neither,
        // so the queue swings between full and empty many times.
        mode = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % BIAS_SPAN == 0)
                mode = $urandom_range(2);
            idle_on = !(n >= QUIET_FIRST && n < QUIET_LAST);
            if (n == PAUSE_AT)
                hold_until_drained();

            roll = $urandom_range(99);
            if (roll < 2)
                op = OP_CLEAR;
            else if (roll < 2 + (mode == 0 ? 60 : mode == 1 ? 15 : 35))
                op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else if (roll < 2 + (mode == 0 ? 75 : mode == 1 ? 70 : 65))
                op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
            else
            begin
                case ($urandom_range(2))
                    0: op = OP_READ_FRONT;
                    1: op = OP_READ_BACK;
                    default: op = OP_READ_INDEX;
                endcase
            end

            case ($urandom_range(9))
                0: data = '0;
                1: data = '1;
                default: data = data_t'($urandom);
            endcase

            if (fill > 0 && $urandom_range(3) != 0)
                pos = pos_t'($urandom_range(fill - 1));
            else
                pos = pos_t'($urandom_range(15));

            issue(op, data, pos, 1'b0, NO_RESULT);
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/deq_dpath.sv
rtl/double_ended_queue_core.sv
dv/tb.sv
